### hw/rtl/dfs_pkg.sv
// Shared types and constants for the depth-first search block.
package dfs_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Reset value of the vertex count register.
  localparam logic [6:0] VCOUNT_RESET = 7'd8;

endpackage

### hw/rtl/dfs_discovery_finish_times.sv
// Top level of the depth-first search block with discovery and finish times.
// Add edge: a tail read, then the edge write; a new item is accepted only once busy falls.
// Clear: a single busy state. Run: a sweep that clears the parent table, then the search
// (discoveries, edges examined, finishes and the scan for unvisited vertices), then one
// result beat per discovered vertex; the last beat shows in the first idle cycle after busy falls.
// The result port has no stall; busy is high while an item is in work.
// Reset is asynchronous and leaves an empty graph with vertex count 8.
module dfs_discovery_finish_times
  import dfs_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic [1:0] action_i,
  input  logic [5:0] from_vertex_i,
  input  logic [5:0] to_vertex_i,
  input  logic [5:0] start_vertex_i,
  output logic       result_valid_o,
  output logic [5:0] vertex_o,
  output logic [6:0] discover_time_o,
  output logic [7:0] finish_time_o,
  output logic [5:0] parent_vertex_o,
  output logic       has_parent_o,
  output logic       edges_dropped_o,
  output logic       last_o
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);
  localparam logic [DW-1:0] NMAX = DW'(MAX_VERTICES);

  // Sequencer codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_DISC  = 4'd4;
  localparam logic [3:0] S_TOP   = 4'd5;
  localparam logic [3:0] S_TOPW  = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_OUTR  = 4'd9;
  localparam logic [3:0] S_OUTV  = 4'd10;
  localparam logic [3:0] S_OUTD  = 4'd11;
  localparam logic [3:0] S_HCLR  = 4'd12;
  localparam logic [3:0] S_SCANW = 4'd13;

  // Memories.
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic [EW-1:0] tail_mem [MAX_VERTICES];
  logic [5:0]    tgt_mem  [MAX_EDGES];
  logic [EW-1:0] link_mem [MAX_EDGES];
  logic [6:0]    disc_mem [MAX_VERTICES];
  logic [7:0]    fin_mem  [MAX_VERTICES];
  logic [6:0]    par_mem  [MAX_VERTICES];
  logic [5:0]    ord_mem  [MAX_VERTICES];
  logic [VW-1:0] stkv_mem [MAX_VERTICES];
  logic [EW-1:0] stke_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] visited_q;
  logic [MAX_VERTICES-1:0] hvalid_q;

  logic [3:0]    state_q;
  logic [6:0]    vcount_q;
  logic [5:0]    from_q, to_q, start_q;
  logic [EW-1:0] used_q;
  logic          drop_q;
  logic [7:0]    time_q;
  logic [DW-1:0] depth_q, order_q, idx_q, scan_q;
  logic [VW-1:0] curv_q, newv_q;
  logic [EW-1:0] cure_q;
  logic [6:0]    newpar_q;
  logic          phase_q;

  // Registered read data.
  logic [EW-1:0] tail_rd_q, head_rd_q, stke_rd_q, link_rd_q;
  logic [VW-1:0] stkv_rd_q;
  logic [5:0]    tgt_rd_q, ord_rd_q;
  logic [6:0]    disc_rd_q, par_rd_q;
  logic [7:0]    fin_rd_q;

  // Clamped vertex count.
  logic [DW-1:0] n_w;
  always_comb begin
    if (vcount_q == 7'd0) n_w = DW'(1);
    else if ({1'b0, vcount_q} > 8'(MAX_VERTICES)) n_w = NMAX;
    else n_w = DW'(vcount_q);
  end

  logic from_ok, to_ok;
  assign from_ok = {2'b0, from_q} < 8'(n_w);
  assign to_ok   = {2'b0, to_q} < 8'(n_w);

  logic [EW-1:0] head_eff;
  assign head_eff = hvalid_q[newv_q] ? head_rd_q : NIL;
  logic [EW-1:0] tail_eff;
  assign tail_eff = hvalid_q[from_q[VW-1:0]] ? tail_rd_q : NIL;

  assign busy = state_q != S_IDLE;

  // Stack top address.
  function automatic logic [VW-1:0] top_idx();
    logic [DW-1:0] t;
    t = depth_q - DW'(1);
    return t[VW-1:0];
  endfunction

  // Vertex count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // Memory reads, registered.
  always_ff @(posedge clk_i) begin
    tail_rd_q <= tail_mem[from_q[VW-1:0]];
    head_rd_q <= head_mem[newv_q];
    stkv_rd_q <= stkv_mem[top_idx()];
    stke_rd_q <= stke_mem[top_idx()];
    tgt_rd_q  <= tgt_mem[cure_q[AW-1:0]];
    link_rd_q <= link_mem[cure_q[AW-1:0]];
    ord_rd_q  <= ord_mem[idx_q[VW-1:0]];
    disc_rd_q <= disc_mem[ord_rd_q[VW-1:0]];
    fin_rd_q  <= fin_mem[ord_rd_q[VW-1:0]];
    par_rd_q  <= par_mem[ord_rd_q[VW-1:0]];
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    // The new edge ends its list; marked while the tail is read.
    if (state_q == S_ADD && !phase_q && from_ok && to_ok && used_q < NIL) begin
      link_mem[used_q[AW-1:0]] <= NIL;
    end
    if (state_q == S_ADD && phase_q && from_ok && to_ok && used_q < NIL) begin
      tgt_mem[used_q[AW-1:0]]  <= to_q;
      if (tail_eff != NIL) link_mem[tail_eff[AW-1:0]] <= used_q;
      if (!hvalid_q[from_q[VW-1:0]]) head_mem[from_q[VW-1:0]] <= used_q;
      tail_mem[from_q[VW-1:0]] <= used_q;
    end
    if (state_q == S_INIT) par_mem[scan_q[VW-1:0]] <= 7'd0;
    if (state_q == S_DISC && phase_q) begin
      disc_mem[newv_q] <= time_q[6:0] + 7'd1;
      par_mem[newv_q]  <= newpar_q;
      ord_mem[order_q[VW-1:0]] <= 6'(newv_q);
      if (depth_q < NMAX) begin
        stkv_mem[depth_q[VW-1:0]] <= newv_q;
        stke_mem[depth_q[VW-1:0]] <= head_eff;
      end
    end
    if (state_q == S_TOPW && stke_rd_q >= NIL) fin_mem[stkv_rd_q] <= time_q + 8'd1;
    if (state_q == S_EDGE && phase_q) stke_mem[top_idx()] <= link_rd_q;
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= 1'b0;
      from_q <= '0; to_q <= '0; start_q <= '0;
      used_q <= '0; drop_q <= 1'b0; hvalid_q <= '0; visited_q <= '0;
      time_q <= '0; depth_q <= '0; order_q <= '0; idx_q <= '0; scan_q <= '0;
      curv_q <= '0; newv_q <= '0; cure_q <= '0; newpar_q <= '0;
      result_valid_o <= 1'b0; last_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == S_OUTD);
      case (state_q)
        S_IDLE: begin
          phase_q <= 1'b0;
          if (start) begin
            from_q <= from_vertex_i; to_q <= to_vertex_i;
            start_q <= start_vertex_i;
            case (action_i)
              ACT_ADD:   state_q <= S_ADD;
              ACT_RUN:   begin state_q <= S_INIT; scan_q <= '0; end
              ACT_CLEAR: state_q <= S_CLR;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (phase_q) begin
            state_q <= S_IDLE;
            if (!from_ok || !to_ok || used_q >= NIL) drop_q <= 1'b1;
            else begin
              used_q <= used_q + EW'(1);
              hvalid_q[from_q[VW-1:0]] <= 1'b1;
            end
          end else begin
            phase_q <= 1'b1;
          end
        end
        S_CLR: begin
          hvalid_q <= '0; used_q <= '0; drop_q <= 1'b0; state_q <= S_IDLE;
        end
        S_INIT: begin
          visited_q <= '0; time_q <= '0; depth_q <= '0; order_q <= '0;
          if (scan_q == NMAX - DW'(1)) begin
            state_q <= S_DISC; phase_q <= 1'b0; newpar_q <= '0;
            newv_q <= ({2'b0, start_q} < 8'(n_w)) ? start_q[VW-1:0] : '0;
            scan_q <= '0;
          end else begin
            scan_q <= scan_q + DW'(1);
          end
        end
        S_DISC: begin
          // First cycle reads the head of the list.
          if (phase_q) begin
            visited_q[newv_q] <= 1'b1;
            time_q <= time_q + 8'd1;
            if (order_q < NMAX) order_q <= order_q + DW'(1);
            if (depth_q < NMAX) depth_q <= depth_q + DW'(1);
            state_q <= S_TOP; phase_q <= 1'b0;
          end else begin
            phase_q <= 1'b1;
          end
        end
        S_TOP: begin
          if (depth_q == '0) begin
            state_q <= S_SCAN;
          end else begin
            state_q <= S_TOPW;
          end
        end
        S_TOPW: begin
          curv_q <= stkv_rd_q;
          if (stke_rd_q >= NIL) begin
            time_q <= time_q + 8'd1;
            depth_q <= depth_q - DW'(1);
            state_q <= S_TOP;
          end else begin
            cure_q <= stke_rd_q; state_q <= S_EDGE; phase_q <= 1'b0;
          end
        end
        S_EDGE: begin
          if (phase_q) begin
            phase_q <= 1'b0;
            if ({2'b0, tgt_rd_q} < 8'(n_w) && !visited_q[tgt_rd_q[VW-1:0]]) begin
              newv_q <= tgt_rd_q[VW-1:0];
              newpar_q <= {1'b1, 6'(curv_q)};
              state_q <= S_DISC;
            end else begin
              state_q <= S_TOP;
            end
          end else begin
            phase_q <= 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_q >= n_w) begin
            state_q <= S_OUTR; idx_q <= '0; phase_q <= 1'b0;
          end else begin
            state_q <= S_SCANW;
          end
        end
        S_SCANW: begin
          scan_q <= scan_q + DW'(1);
          if (!visited_q[scan_q[VW-1:0]]) begin
            newv_q <= scan_q[VW-1:0]; newpar_q <= '0; state_q <= S_DISC;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_OUTR: state_q <= S_OUTV;
        S_OUTV: state_q <= S_OUTD;
        S_OUTD: begin
          last_o <= (idx_q + DW'(1)) == order_q;
          idx_q <= idx_q + DW'(1);
          state_q <= ((idx_q + DW'(1)) == order_q) ? S_IDLE : S_OUTR;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result fields.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUTD) begin
      vertex_o        <= ord_rd_q;
      discover_time_o <= disc_rd_q;
      finish_time_o   <= fin_rd_q;
      parent_vertex_o <= par_rd_q[6] ? par_rd_q[5:0] : 6'd0;
      has_parent_o    <= par_rd_q[6];
      edges_dropped_o <= drop_q;
    end
  end

endmodule

### tb/sv/dfs_discovery_finish_times_checker.sv
// Checker that predicts and compares the traversal results of the depth-first search block.
`timescale 1ns / 1ps
module dfs_discovery_finish_times_checker
  import dfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic [1:0] action_i,
  input  logic [5:0] from_vertex_i,
  input  logic [5:0] to_vertex_i,
  input  logic [5:0] start_vertex_i,
  input  logic       result_valid_i,
  input  logic [5:0] vertex_i,
  input  logic [6:0] discover_time_i,
  input  logic [7:0] finish_time_i,
  input  logic [5:0] parent_vertex_i,
  input  logic       has_parent_i,
  input  logic       edges_dropped_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int NV = 64;
  localparam int NE = 1024;

  typedef struct packed {
    logic [5:0] vertex;
    logic [6:0] disc;
    logic [7:0] fin;
    logic [5:0] parent;
    logic       has_parent;
    logic       dropped;
    logic       last;
  } visit_t;

  // Predicted graph and register state.
  logic [6:0]  vcount;
  int          head [NV];
  int          tail [NV];
  logic [5:0]  tgt [NE];
  int          lnk [NE];
  int          used;
  logic        dropped;

  // Per-run traversal state.
  logic        seen [NV];
  logic [5:0]  par [NV];
  logic        parv [NV];
  int          disc [NV];
  int          fin [NV];
  logic [5:0]  order [NV];
  logic [5:0]  stk_v [NV];
  int          stk_e [NV];
  int          depth;
  int          clock_cnt;
  int          order_cnt;

  visit_t      visits_due [$];

  assign pending_o = visits_due.size();

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  task automatic clear_graph();
    for (int i = 0; i < NV; i++) begin
      head[i] = NE;
      tail[i] = NE;
    end
    used = 0;
    dropped = 1'b0;
  endtask

  task automatic discover(int v);
    seen[v] = 1'b1;
    clock_cnt = (clock_cnt + 1) & 8'hFF;
    disc[v] = clock_cnt;
    if (order_cnt < NV) begin
      order[order_cnt] = v[5:0];
      order_cnt++;
    end
    if (depth < NV) begin
      stk_v[depth] = v[5:0];
      stk_e[depth] = head[v];
      depth++;
    end
  endtask

  task automatic walk(int root, int n);
    int v;
    int e;
    int t;
    discover(root);
    while (depth > 0) begin
      v = stk_v[depth-1];
      e = stk_e[depth-1];
      if (e >= NE) begin
        clock_cnt = (clock_cnt + 1) & 8'hFF;
        fin[v] = clock_cnt;
        depth--;
      end else begin
        t = tgt[e];
        stk_e[depth-1] = lnk[e];
        if (t < n && !seen[t]) begin
          par[t] = v[5:0];
          parv[t] = 1'b1;
          discover(t);
        end
      end
    end
  endtask

  // Applies one accepted item to the predicted state.
  task automatic apply_item(logic [1:0] act, int src, int dst, int root);
    int n;
    visit_t r;
    n = (vcount < 1) ? 1 : (vcount > NV) ? NV : int'(vcount);
    case (act)
      ACT_ADD: begin
        if (src >= n || dst >= n || used >= NE) begin
          dropped = 1'b1;
        end else begin
          tgt[used] = dst[5:0];
          lnk[used] = NE;
          if (head[src] >= NE) head[src] = used;
          else lnk[tail[src]] = used;
          tail[src] = used;
          used++;
        end
      end
      ACT_CLEAR: clear_graph();
      ACT_RUN: begin
        for (int i = 0; i < NV; i++) begin
          seen[i] = 1'b0;
          parv[i] = 1'b0;
          par[i] = '0;
        end
        clock_cnt = 0;
        depth = 0;
        order_cnt = 0;
        if (root >= n) root = 0;
        walk(root, n);
        for (int i = 0; i < n; i++) if (!seen[i]) walk(i, n);
        for (int i = 0; i < order_cnt; i++) begin
          r.vertex = order[i];
          r.disc = disc[order[i]][6:0];
          r.fin = fin[order[i]][7:0];
          r.parent = parv[order[i]] ? par[order[i]] : 6'd0;
          r.has_parent = parv[order[i]];
          r.dropped = dropped;
          r.last = (i + 1 == order_cnt);
          visits_due.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Compare result beats, then track configuration writes and accepted items.
  always @(posedge clk_i or negedge rst_ni) begin
    visit_t w;
    if (!rst_ni) begin
      vcount = VCOUNT_RESET;
      clear_graph();
      visits_due.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_i) begin
        if (visits_due.size() == 0) begin
          report("unexpected result beat, vertex", vertex_i, -1);
        end else begin
          w = visits_due.pop_front();
          if (vertex_i !== w.vertex) report("vertex", vertex_i, w.vertex);
          if (discover_time_i !== w.disc) report("discover_time", discover_time_i, w.disc);
          if (finish_time_i !== w.fin) report("finish_time", finish_time_i, w.fin);
          if (parent_vertex_i !== w.parent) report("parent_vertex", parent_vertex_i, w.parent);
          if (has_parent_i !== w.has_parent) report("has_parent", has_parent_i, w.has_parent);
          if (edges_dropped_i !== w.dropped) report("edges_dropped", edges_dropped_i, w.dropped);
          if (last_i !== w.last) report("last", last_i, w.last);
        end
      end
      if (cfg_we_i) vcount = cfg_wdata_i;
      if (start && !busy) apply_item(action_i, from_vertex_i, to_vertex_i, start_vertex_i);
    end
  end

endmodule

### tb/sv/dfs_discovery_finish_times_test.sv
// Top of the testbench: drives items and register writes and judges the run.
`timescale 1ns / 1ps
module dfs_discovery_finish_times_test;
  import dfs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic [1:0] action_i;
  logic [5:0] from_vertex_i;
  logic [5:0] to_vertex_i;
  logic [5:0] start_vertex_i;
  logic       result_valid_o;
  logic [5:0] vertex_o;
  logic [6:0] discover_time_o;
  logic [7:0] finish_time_o;
  logic [5:0] parent_vertex_o;
  logic       has_parent_o;
  logic       edges_dropped_o;
  logic       last_o;
  int         fail_count;
  int         visits_pending;
  int         idle_pct;
  int         vcount_now;
  int         quiet_cycles;

  dfs_discovery_finish_times u_dut (.*);

  dfs_discovery_finish_times_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i,
    .action_i, .from_vertex_i, .to_vertex_i, .start_vertex_i,
    .result_valid_i(result_valid_o),
    .vertex_i(vertex_o), .discover_time_i(discover_time_o), .finish_time_i(finish_time_o),
    .parent_vertex_i(parent_vertex_o), .has_parent_i(has_parent_o),
    .edges_dropped_i(edges_dropped_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(visits_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one item, with an optional idle gap first, and returns at the accepting edge.
  task automatic send(logic [1:0] act, int src, int dst, int root);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    from_vertex_i <= src[5:0];
    to_vertex_i <= dst[5:0];
    start_vertex_i <= root[5:0];
    do @(posedge clk_i); while (busy);
  endtask

  // Writes the vertex count once every result has drained and the block is idle.
  task automatic set_vcount(int v);
    start <= 1'b0;
    do @(posedge clk_i); while (visits_pending != 0 || busy);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[6:0];
    vcount_now = (v < 1) ? 1 : (v > 64) ? 64 : v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Loads a random graph and runs it once or twice.
  task automatic random_graph(int edges);
    int n;
    n = vcount_now;
    send(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(99) < 90) send(ACT_ADD, $urandom_range(n-1), $urandom_range(n-1), 0);
      else send($urandom_range(99) < 50 ? ACT_ADD : ACT_NONE, $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(1, 2)) begin
      send(ACT_RUN, 0, 0, $urandom_range(99) < 80 ? $urandom_range(n-1) : $urandom_range(63));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    action_i = ACT_ADD;
    from_vertex_i = '0;
    to_vertex_i = '0;
    start_vertex_i = '0;
    idle_pct = 0;
    vcount_now = 8;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: run an empty graph at reset size, a small chain, bad edges, bad start.
    send(ACT_RUN, 0, 0, 3);
    send(ACT_ADD, 0, 1, 0);
    send(ACT_ADD, 1, 2, 0);
    send(ACT_ADD, 2, 0, 0);
    send(ACT_ADD, 0, 7, 0);
    send(ACT_ADD, 8, 1, 0);
    send(ACT_ADD, 1, 63, 0);
    send(ACT_NONE, 63, 63, 63);
    send(ACT_RUN, 0, 0, 2);
    send(ACT_RUN, 0, 0, 63);
    send(ACT_CLEAR, 0, 0, 0);
    send(ACT_RUN, 0, 0, 5);

    // Extremes of the vertex count.
    set_vcount(0);
    send(ACT_ADD, 0, 0, 0);
    send(ACT_ADD, 0, 1, 0);
    send(ACT_RUN, 0, 0, 63);
    set_vcount(127);
    send(ACT_ADD, 63, 62, 0);
    send(ACT_ADD, 62, 63, 0);
    send(ACT_ADD, 0, 63, 0);
    send(ACT_RUN, 0, 0, 63);

    // Stale edges: load at 16 vertices, then run at 4.
    set_vcount(16);
    send(ACT_CLEAR, 0, 0, 0);
    send(ACT_ADD, 0, 12, 0);
    send(ACT_ADD, 0, 3, 0);
    send(ACT_ADD, 3, 15, 0);
    set_vcount(4);
    send(ACT_RUN, 0, 0, 1);

    // A random graph over all vertices.
    set_vcount(64);
    send(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 20; i++) send(ACT_ADD, $urandom_range(63), $urandom_range(63), 0);
    send(ACT_RUN, 0, 0, $urandom_range(63));

    // Random phases: no idling, heavy sender idling, light idling.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 77 : 7;
      for (int g = 0; g < 3; g++) begin
        case ($urandom_range(5))
          0: set_vcount(1);
          1: set_vcount(2);
          2: set_vcount($urandom_range(3, 10));
          3: set_vcount($urandom_range(11, 63));
          4: set_vcount(64);
          default: set_vcount($urandom_range(65, 127));
        endcase
        random_graph($urandom_range(0, 8));
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (visits_pending != 0 || busy);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
